/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/epsf_pkg.sv */
// ----------------------------------------------------------------------------
// epsf_pkg
// Types, constants and search functions for the binary64 exact product split.
// ----------------------------------------------------------------------------
package epsf_pkg;

  localparam int MANT_W = 53;
  localparam int PROD_W = 106;
  localparam int DIFF_W = 107;
  localparam int EXT_W  = DIFF_W + MANT_W + 1;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] EXP_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;

  typedef logic signed [15:0] exp_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        neg;
    exp_t        e;
  } side_t;

  function automatic logic [5:0] lzc53(input logic [MANT_W-1:0] v);
    logic [5:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = MANT_W - 1; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [6:0] lzc107(input logic [DIFF_W-1:0] v);
    logic [6:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = DIFF_W - 1; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 7'd1;
      end
    end
    return n;
  endfunction

endpackage

/* design/exact_product_split_f64.sv */
// ----------------------------------------------------------------------------
// exact_product_split_f64
// Binary64 product rounded to nearest even, with its rounding error as lo.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    in_x_bits, in_y_bits
// out_     output     out_valid / out_stall  out_hi_bits, out_lo_bits
//
// Every request passes eight register stages before its result is presented.
// One request can enter in every cycle in which in_stall is low.
// The stages are input normalization, partial products, product sum, hi shift,
// hi rounding, error search, lo shift and lo rounding with the output register.
// A stall only holds stages that are full, so bubbles close up behind a stall.
// Reset is synchronous and clears the valid bits only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module exact_product_split_f64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_x_bits,
  input  logic [63:0] in_y_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hi_bits,
  output logic [63:0] out_lo_bits
);

  logic [8:1] v_r;
  logic [8:1] en;

  epsf_pkg::side_t side1_nxt, side1_r, side2_r, side3_r, side4_r;
  epsf_pkg::side_t side5_nxt, side5_r, side6_r, side7_r;
  logic [52:0]  mx_nxt, mx_r, my_nxt, my_r;
  logic [53:0]  pp_ll_nxt, pp_ll_r;
  logic [52:0]  pp_lh_nxt, pp_lh_r, pp_hl_nxt, pp_hl_r;
  logic [51:0]  pp_hh_nxt, pp_hh_r;
  logic [105:0] p_nxt, p_r;
  logic [53:0]  q4_nxt, q4_r;
  logic         g4_nxt, g4_r, st4_nxt, st4_r;
  logic [106:0] rem4_nxt, rem4_r;
  logic [6:0]   s4_nxt, s4_r;
  epsf_pkg::exp_t qexp4_nxt, qexp4_r;
  logic [106:0] diff5_nxt, diff5_r, diff6_r;
  logic [6:0]   len6_nxt, len6_r;
  logic [53:0]  q7_nxt, q7_r;
  logic         g7_nxt, g7_r, st7_nxt, st7_r;
  epsf_pkg::exp_t qexp7_nxt, qexp7_r;
  logic [63:0]  hi8_nxt, hi8_r, lo8_nxt, lo8_r;

  always_comb begin
    en[8] = !v_r[8] || !out_stall;
    for (int k = 7; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_stall    = !en[1];
  assign out_valid   = v_r[8];
  assign out_hi_bits = hi8_r;
  assign out_lo_bits = lo8_r;

  // Stage 1: special operands and normalized significands.
  always_comb begin
    logic [10:0] ex, ey;
    logic [51:0] fx, fy;
    logic        neg, x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [52:0] mx, my;
    logic [5:0]  lx, ly;
    ex     = in_x_bits[62:52];
    ey     = in_y_bits[62:52];
    fx     = in_x_bits[51:0];
    fy     = in_y_bits[51:0];
    neg    = in_x_bits[63] ^ in_y_bits[63];
    x_nan  = (ex == epsf_pkg::EXP_MAX) && (fx != '0);
    y_nan  = (ey == epsf_pkg::EXP_MAX) && (fy != '0);
    x_inf  = (ex == epsf_pkg::EXP_MAX);
    y_inf  = (ey == epsf_pkg::EXP_MAX);
    x_zero = (ex == '0) && (fx == '0);
    y_zero = (ey == '0) && (fy == '0);
    mx     = {ex != '0, fx};
    my     = {ey != '0, fy};
    lx     = epsf_pkg::lzc53(mx);
    ly     = epsf_pkg::lzc53(my);
    mx_nxt = mx << lx;
    my_nxt = my << ly;
    side1_nxt.neg  = neg;
    side1_nxt.done = 1'b1;
    side1_nxt.hi   = epsf_pkg::CANON_NAN;
    side1_nxt.lo   = epsf_pkg::CANON_NAN;
    side1_nxt.e    = epsf_pkg::exp_t'((ex != '0) ? ex : 11'd1)
                   + epsf_pkg::exp_t'((ey != '0) ? ey : 11'd1)
                   - epsf_pkg::exp_t'(2150)
                   - epsf_pkg::exp_t'(lx) - epsf_pkg::exp_t'(ly);
    priority if (x_nan) begin
      side1_nxt.hi = in_x_bits | epsf_pkg::QUIET_BIT;
    end else if (y_nan) begin
      side1_nxt.hi = in_y_bits | epsf_pkg::QUIET_BIT;
    end else if ((x_inf && y_zero) || (y_inf && x_zero)) begin
      side1_nxt.hi = epsf_pkg::CANON_NAN;
    end else if (x_inf || y_inf) begin
      side1_nxt.hi = (neg ? epsf_pkg::SIGN_BIT : '0) | epsf_pkg::EXP_INF;
    end else if (x_zero || y_zero) begin
      side1_nxt.hi = neg ? epsf_pkg::SIGN_BIT : '0;
      side1_nxt.lo = '0;
    end else begin
      side1_nxt.done = 1'b0;
    end
  end

  // Stage 2: four partial products.
  always_comb begin
    pp_ll_nxt = 54'(mx_r[26:0]) * 54'(my_r[26:0]);
    pp_lh_nxt = 53'(mx_r[26:0]) * 53'(my_r[52:27]);
    pp_hl_nxt = 53'(mx_r[52:27]) * 53'(my_r[26:0]);
    pp_hh_nxt = 52'(mx_r[52:27]) * 52'(my_r[52:27]);
  end

  // Stage 3: full product.
  assign p_nxt = 106'(pp_ll_r) + (106'(pp_lh_r) << 27) + (106'(pp_hl_r) << 27)
               + (106'(pp_hh_r) << 54);

  // Stage 4: hi alignment, guard and sticky.
  always_comb begin
    logic [6:0]     lenp;
    epsf_pkg::exp_t top, sr;
    logic [106:0]   pe, mask;
    lenp = p_r[105] ? 7'd106 : 7'd105;
    top  = side3_r.e + epsf_pkg::exp_t'(lenp) - epsf_pkg::exp_t'(1);
    sr   = epsf_pkg::exp_t'(-1074) - side3_r.e;
    if (top >= epsf_pkg::exp_t'(-1022)) s4_nxt = lenp - 7'd53;
    else if (sr > epsf_pkg::exp_t'(107)) s4_nxt = 7'd107;
    else s4_nxt = sr[6:0];
    pe        = {1'b0, p_r};
    mask      = ~({epsf_pkg::DIFF_W{1'b1}} << s4_nxt);
    q4_nxt    = 54'(pe >> s4_nxt);
    g4_nxt    = pe[s4_nxt - 7'd1];
    st4_nxt   = |(pe & (mask >> 1));
    rem4_nxt  = pe & mask;
    qexp4_nxt = side3_r.e + epsf_pkg::exp_t'(s4_nxt);
  end

  // Stage 5: hi rounding and packing, error magnitude.
  always_comb begin
    logic           rup, inexact, ovf;
    logic [53:0]    q, qn;
    epsf_pkg::exp_t qexp, biased;
    rup     = g4_r && (st4_r || q4_r[0]);
    inexact = g4_r || st4_r;
    q       = q4_r + 54'(rup);
    qn      = q[53] ? (q >> 1) : q;
    qexp    = q[53] ? (qexp4_r + epsf_pkg::exp_t'(1)) : qexp4_r;
    biased  = qn[52] ? (qexp + epsf_pkg::exp_t'(1075)) : epsf_pkg::exp_t'(0);
    ovf     = biased >= epsf_pkg::exp_t'(2047);
    side5_nxt = side4_r;
    if (!side4_r.done) begin
      side5_nxt.neg = side4_r.neg ^ rup;
      if (ovf) begin
        side5_nxt.done = 1'b1;
        side5_nxt.hi   = (side4_r.neg ? epsf_pkg::SIGN_BIT : '0) | epsf_pkg::EXP_INF;
        side5_nxt.lo   = epsf_pkg::CANON_NAN;
      end else begin
        side5_nxt.hi   = {side4_r.neg, biased[10:0], qn[51:0]};
        side5_nxt.done = !inexact;
        side5_nxt.lo   = '0;
      end
    end
    diff5_nxt = rup ? 107'((108'(1) << s4_r) - 108'(rem4_r)) : rem4_r;
  end

  // Stage 6: leading one of the error.
  assign len6_nxt = 7'(7'd107 - epsf_pkg::lzc107(diff5_r));

  // Stage 7: lo alignment, guard and sticky.
  always_comb begin
    epsf_pkg::exp_t top, sr, s2;
    logic [7:0]     amt;
    logic [160:0]   ext;
    top = side6_r.e + epsf_pkg::exp_t'(len6_r) - epsf_pkg::exp_t'(1);
    sr  = epsf_pkg::exp_t'(-1074) - side6_r.e;
    if (top >= epsf_pkg::exp_t'(-1022)) s2 = epsf_pkg::exp_t'(len6_r) - epsf_pkg::exp_t'(53);
    else if (sr > epsf_pkg::exp_t'(108)) s2 = epsf_pkg::exp_t'(108);
    else s2 = sr;
    amt       = 8'(s2 + epsf_pkg::exp_t'(53));
    ext       = {1'b0, diff6_r, 53'b0};
    q7_nxt    = 54'(ext >> amt);
    g7_nxt    = ext[amt - 8'd1];
    st7_nxt   = |(ext & ~({epsf_pkg::EXT_W{1'b1}} << (amt - 8'd1)));
    qexp7_nxt = side6_r.e + s2;
  end

  // Stage 8: lo rounding and output register.
  always_comb begin
    logic           rup;
    logic [53:0]    q, qn;
    epsf_pkg::exp_t qexp, biased;
    rup    = g7_r && (st7_r || q7_r[0]);
    q      = q7_r + 54'(rup);
    qn     = q[53] ? (q >> 1) : q;
    qexp   = q[53] ? (qexp7_r + epsf_pkg::exp_t'(1)) : qexp7_r;
    biased = qn[52] ? (qexp + epsf_pkg::exp_t'(1075)) : epsf_pkg::exp_t'(0);
    hi8_nxt = side7_r.hi;
    lo8_nxt = side7_r.done ? side7_r.lo : {side7_r.neg, biased[10:0], qn[51:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side1_r <= side1_nxt;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
    end
    if (en[2]) begin
      side2_r <= side1_r;
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
    end
    if (en[3]) begin
      side3_r <= side2_r;
      p_r     <= p_nxt;
    end
    if (en[4]) begin
      side4_r <= side3_r;
      q4_r    <= q4_nxt;
      g4_r    <= g4_nxt;
      st4_r   <= st4_nxt;
      rem4_r  <= rem4_nxt;
      s4_r    <= s4_nxt;
      qexp4_r <= qexp4_nxt;
    end
    if (en[5]) begin
      side5_r <= side5_nxt;
      diff5_r <= diff5_nxt;
    end
    if (en[6]) begin
      side6_r <= side5_r;
      diff6_r <= diff5_r;
      len6_r  <= len6_nxt;
    end
    if (en[7]) begin
      side7_r <= side6_r;
      q7_r    <= q7_nxt;
      g7_r    <= g7_nxt;
      st7_r   <= st7_nxt;
      qexp7_r <= qexp7_nxt;
    end
    if (en[8]) begin
      hi8_r <= hi8_nxt;
      lo8_r <= lo8_nxt;
    end
  end

  `ASSERT_CLK(a_stall_only_when_full, in_stall |-> (out_valid && out_stall), "input stalled while the output is free")
  `ASSERT_CLK(a_nonfinite_hi_nan_lo, (out_valid && (out_hi_bits[62:52] == epsf_pkg::EXP_MAX)) |-> (out_lo_bits == epsf_pkg::CANON_NAN), "lo is not the canonical NaN for a non-finite hi")
  `ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule
